FILE: rtl/multi_list_store_engine_core_assert.svh
// assertion macros for the list store engine
`ifndef MULTI_LIST_STORE_ENGINE_CORE_ASSERT_SVH
`define MULTI_LIST_STORE_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MLSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MLSE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define MLSE_ASSERT(label, prop, msg)
`define MLSE_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

FILE: rtl/mlse_pkg.sv
`default_nettype none

package mlse_pkg;

  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int AMOUNT_W = 7;
  localparam int COUNT_W  = 5;

  typedef enum logic [2:0] {
    REQ_CREATE = 3'd0,
    REQ_APPEND = 3'd1,
    REQ_DROP   = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_READ   = 3'd4,
    REQ_RESIZE = 3'd5
  } req_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_BAD_POS  = 4'd1,
    ST_BAD_SIZE = 4'd2,
    ST_EXISTS   = 4'd3,
    ST_NO_MEM   = 4'd4,
    ST_FULL     = 4'd5,
    ST_NO_LIST  = 4'd6,
    ST_EMPTY    = 4'd7,
    ST_ABSENT   = 4'd8
  } status_e;

endpackage

`default_nettype wire

FILE: rtl/mlse_ram.sv
`default_nettype none

module mlse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [ADDR_W-1:0]     waddr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic [ADDR_W-1:0]     raddr_i,
  output logic      [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/multi_list_store_engine_core.sv
// numbered bounded lists held in one shared element store with one read and one write port
// input channel: in_valid_i / in_stall_o with req_type_i, list_position_i,
//   item_value_i and amount_i; a transfer happens when valid is high and stall low
// output channel: out_valid_o / out_stall_i with status_o, data_value_o,
//   data_valid_o, fill_count_o and last_result_o from one output register
// one request at a time: in_stall_o stays high from the transfer until the
//   request has handed its last result to the output register
// create, append, drop, resize, a read of an empty list and errors: the request
//   passes through S_CHECK and S_RESP, and S_RESP loads the result into the output register
// delete: S_SCAN then S_SHIFT, one element compared or moved per cycle, then S_RESP
// read all: one element per cycle through the store read port while the receiver does not stall
// unknown request codes are taken and dropped without a result
// while the receiver stalls, the result holds and the sequencer waits on it
// reset clears all list flags, capacities and fill counts; the element store
//   has no reset since only slots below a fill count are ever read
`default_nettype none
`include "multi_list_store_engine_core_assert.svh"

module multi_list_store_engine_core #(
  parameter int NUM_LISTS    = 10,
  parameter int MAX_CAPACITY = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [3:0]  list_position_i,
  input  wire logic [31:0] item_value_i,
  input  wire logic [6:0]  amount_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       status_o,
  output logic [31:0]      data_value_o,
  output logic             data_valid_o,
  output logic [4:0]       fill_count_o,
  output logic             last_result_o
);

  localparam int LI_W   = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int CNT_W  = $clog2(MAX_CAPACITY + 1);
  localparam int DEPTH  = NUM_LISTS * MAX_CAPACITY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = CNT_W + 8;
  localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1);
  localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'(MAX_CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_READ  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // latched request
  mlse_pkg::req_e            req_q;
  logic [LI_W-1:0]           li_q;
  logic                      pos_bad_q;
  logic [31:0]               val_q;
  logic signed [6:0]         amt_q;

  logic [CNT_W-1:0]          idx_q, idx_d;
  mlse_pkg::status_e         res_st_q, res_st_d;
  logic [CNT_W-1:0]          res_cnt_q, res_cnt_d;

  // per-list bookkeeping
  logic                      alloc_q [NUM_LISTS];
  logic [CNT_W-1:0]          cap_q   [NUM_LISTS];
  logic [CNT_W-1:0]          fill_q  [NUM_LISTS];
  logic                      cur_alloc;
  logic [CNT_W-1:0]          cur_cap, cur_fill;
  logic                      meta_we;
  logic                      meta_alloc_d;
  logic [CNT_W-1:0]          meta_cap_d, meta_fill_d;

  // output register
  logic                      out_valid_q;
  mlse_pkg::status_e         status_q;
  logic [31:0]               data_q;
  logic                      dvalid_q;
  logic [4:0]                fcnt_q;
  logic                      last_q;
  logic                      out_free, out_ld;
  mlse_pkg::status_e         ld_status;
  logic [31:0]               ld_data;
  logic                      ld_dvalid;
  logic [CNT_W-1:0]          ld_cnt;
  logic                      ld_last;

  // store port
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr, base;
  logic [31:0]               ram_wdata;
  logic [31:0]               ram_rdata;

  logic                      in_acc, req_known;
  logic signed [SUM_W-1:0]   amt_s, cap_s, ns_s;
  logic                      idx_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign req_known  = (req_type_i inside {[mlse_pkg::REQ_CREATE:mlse_pkg::REQ_RESIZE]});
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cur_alloc = 1'b0;
    cur_cap   = '0;
    cur_fill  = '0;
    for (int k = 0; k < NUM_LISTS; k++) begin
      if (li_q == LI_W'(k)) begin
        cur_alloc = alloc_q[k];
        cur_cap   = cap_q[k];
        cur_fill  = fill_q[k];
      end
    end
  end

  assign base      = ADDR_W'(ADDR_W'(li_q) * ADDR_W'(MAX_CAPACITY));
  assign ram_raddr = base + ADDR_W'(idx_d);
  assign amt_s     = SUM_W'(amt_q);
  assign cap_s     = $signed(SUM_W'(cur_cap));
  assign ns_s      = cap_s + amt_s;
  assign idx_last  = (idx_q == cur_fill - CNT_W'(1));

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    res_st_d     = res_st_q;
    res_cnt_d    = res_cnt_q;
    meta_we      = 1'b0;
    meta_alloc_d = cur_alloc;
    meta_cap_d   = cur_cap;
    meta_fill_d  = cur_fill;
    ram_we       = 1'b0;
    ram_waddr    = base + ADDR_W'(cur_fill);
    ram_wdata    = val_q;
    out_ld       = 1'b0;
    ld_status    = mlse_pkg::ST_OK;
    ld_data      = '0;
    ld_dvalid    = 1'b0;
    ld_cnt       = res_cnt_q;
    ld_last      = 1'b1;

    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (in_acc && req_known) begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        state_d   = S_RESP;
        res_cnt_d = cur_fill;
        res_st_d  = mlse_pkg::ST_OK;
        if (pos_bad_q) begin
          res_st_d  = mlse_pkg::ST_BAD_POS;
          res_cnt_d = '0;
        end else begin
          case (req_q)
            mlse_pkg::REQ_CREATE: begin
              if (amt_s < ONE_S) begin
                res_st_d = mlse_pkg::ST_BAD_SIZE;
              end else if (cur_alloc) begin
                res_st_d = mlse_pkg::ST_EXISTS;
              end else if (amt_s > MAX_S) begin
                res_st_d = mlse_pkg::ST_NO_MEM;
              end else begin
                meta_we      = 1'b1;
                meta_alloc_d = 1'b1;
                meta_cap_d   = CNT_W'(amt_q);
                meta_fill_d  = '0;
                res_cnt_d    = '0;
              end
            end
            mlse_pkg::REQ_RESIZE: begin
              if (ns_s < ONE_S) begin
                res_st_d = mlse_pkg::ST_BAD_SIZE;
              end else if (!cur_alloc) begin
                res_st_d = mlse_pkg::ST_NO_LIST;
              end else if (ns_s > MAX_S) begin
                res_st_d = mlse_pkg::ST_NO_MEM;
              end else begin
                meta_we    = 1'b1;
                meta_cap_d = CNT_W'(ns_s);
                if (cur_fill > CNT_W'(ns_s)) begin
                  meta_fill_d = CNT_W'(ns_s);
                end
                res_cnt_d = meta_fill_d;
              end
            end
            default: begin
              if (!cur_alloc) begin
                res_st_d = mlse_pkg::ST_NO_LIST;
              end else begin
                case (req_q)
                  mlse_pkg::REQ_APPEND: begin
                    if (cur_fill < cur_cap && cur_fill < CNT_W'(MAX_CAPACITY)) begin
                      ram_we      = 1'b1;
                      meta_we     = 1'b1;
                      meta_fill_d = cur_fill + CNT_W'(1);
                      res_cnt_d   = meta_fill_d;
                    end else begin
                      res_st_d = mlse_pkg::ST_FULL;
                    end
                  end
                  mlse_pkg::REQ_DROP: begin
                    if (cur_fill == '0) begin
                      res_st_d = mlse_pkg::ST_EMPTY;
                    end else begin
                      meta_we     = 1'b1;
                      meta_fill_d = cur_fill - CNT_W'(1);
                      res_cnt_d   = meta_fill_d;
                    end
                  end
                  mlse_pkg::REQ_DELETE: begin
                    if (cur_fill == '0) begin
                      res_st_d = mlse_pkg::ST_EMPTY;
                    end else begin
                      idx_d   = '0;
                      state_d = S_SCAN;
                    end
                  end
                  mlse_pkg::REQ_READ: begin
                    if (cur_fill != '0) begin
                      idx_d   = '0;
                      state_d = S_READ;
                    end
                  end
                  default: begin
                    state_d = S_RESP;
                  end
                endcase
              end
            end
          endcase
        end
      end

      // compare one stored element per cycle against the value
      S_SCAN: begin
        if (ram_rdata == val_q) begin
          if (idx_last) begin
            meta_we     = 1'b1;
            meta_fill_d = cur_fill - CNT_W'(1);
            res_st_d    = mlse_pkg::ST_OK;
            res_cnt_d   = meta_fill_d;
            state_d     = S_RESP;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_SHIFT;
          end
        end else if (idx_last) begin
          res_st_d  = mlse_pkg::ST_ABSENT;
          res_cnt_d = cur_fill;
          state_d   = S_RESP;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end

      // move element idx down by one slot
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = base + ADDR_W'(idx_q - CNT_W'(1));
        ram_wdata = ram_rdata;
        if (idx_last) begin
          meta_we     = 1'b1;
          meta_fill_d = cur_fill - CNT_W'(1);
          res_st_d    = mlse_pkg::ST_OK;
          res_cnt_d   = meta_fill_d;
          state_d     = S_RESP;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end

      S_READ: begin
        if (out_free) begin
          out_ld    = 1'b1;
          ld_data   = ram_rdata;
          ld_dvalid = 1'b1;
          ld_cnt    = cur_fill;
          ld_last   = idx_last;
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_ld    = 1'b1;
          ld_status = res_st_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  mlse_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_LISTS; k++) begin
        alloc_q[k] <= 1'b0;
        cap_q[k]   <= '0;
        fill_q[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      for (int k = 0; k < NUM_LISTS; k++) begin
        if (meta_we && li_q == LI_W'(k)) begin
          alloc_q[k] <= meta_alloc_d;
          cap_q[k]   <= meta_cap_d;
          fill_q[k]  <= meta_fill_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q     <= mlse_pkg::req_e'(req_type_i);
      li_q      <= LI_W'(list_position_i - 4'd1);
      pos_bad_q <= (list_position_i == 4'd0) ||
                   ({1'b0, list_position_i} > 5'(NUM_LISTS));
      val_q     <= item_value_i;
      amt_q     <= amount_i;
    end
    idx_q     <= idx_d;
    res_st_q  <= res_st_d;
    res_cnt_q <= res_cnt_d;
    if (out_ld) begin
      status_q <= ld_status;
      data_q   <= ld_data;
      dvalid_q <= ld_dvalid;
      fcnt_q   <= 5'(ld_cnt);
      last_q   <= ld_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_value_o  = data_q;
  assign data_valid_o  = dvalid_q;
  assign fill_count_o  = fcnt_q;
  assign last_result_o = last_q;

  for (genvar k = 0; k < NUM_LISTS; k++) begin : g_list_chk
    `MLSE_ASSERT(a_fill_le_cap, fill_q[k] <= cap_q[k], "fill count above capacity")
    `MLSE_ASSERT(a_cap_le_max, cap_q[k] <= CNT_W'(MAX_CAPACITY), "capacity above maximum")
  end

  `MLSE_ASSERT(a_data_ok, (out_valid_q && dvalid_q) |-> (status_q == mlse_pkg::ST_OK), "element with error status")
  `MLSE_ASSERT(a_single_last, (out_valid_q && !dvalid_q) |-> last_q, "non-element result not final")
  `MLSE_ASSERT_NEXT(a_start, in_acc && req_known, state_q == S_CHECK, "known request not started")

endmodule

`default_nettype wire
